/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, all clocked on clk, ASSERT_CLK disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked only out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* rtl/surng_pkg.sv */
// ----------------------------------------------------------------------------
// surng_pkg
// constants, types and helpers for the subtractive uniform generator
// ----------------------------------------------------------------------------
package surng_pkg;

	localparam int VAL_W      = 30;
	localparam int SEED_W     = 28;
	localparam int LEN        = 55;
	localparam int IDX_W      = $clog2(LEN + 1);
	localparam int SCATTER    = 21;
	localparam int LAG        = 30;
	localparam int TRAIL_INIT = 31;
	localparam int MIX_PASSES = 4;
	localparam int PASS_W     = $clog2(MIX_PASSES);

	localparam logic [VAL_W-1:0]  MODULUS = VAL_W'(1000000000);
	localparam logic [SEED_W-1:0] MSEED   = SEED_W'(161803398);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [VAL_W-1:0] val_t;

	// datapath operations issued by the controller
	typedef logic [2:0] op_t;
	localparam op_t OP_NONE    = 3'd0;
	localparam op_t OP_SEED0   = 3'd1;
	localparam op_t OP_FILL    = 3'd2;
	localparam op_t OP_MIX_RD  = 3'd3;
	localparam op_t OP_MIX_WR  = 3'd4;
	localparam op_t OP_DRAW_RD = 3'd5;
	localparam op_t OP_DRAW_WR = 3'd6;

	typedef struct packed {
		logic fill_last;
		logic mix_last;
		logic out_busy;
	} dp_status_t;

	// a - b modulo MODULUS, both operands below MODULUS
	function automatic val_t sub_mod(input val_t a, input val_t b);
		logic [VAL_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[VAL_W]) begin
			d = d + {1'b0, MODULUS};
		end
		return d[VAL_W-1:0];
	endfunction

	// pointer runs 1..LEN and wraps to 1
	function automatic idx_t advance(input idx_t p);
		if (p >= idx_t'(1) && p < idx_t'(LEN)) begin
			return p + idx_t'(1);
		end
		return idx_t'(1);
	endfunction

endpackage

/* rtl/surng_dp.sv */
// ----------------------------------------------------------------------------
// surng_dp
// lag table memory, seeding registers, pointers and the output register
// ----------------------------------------------------------------------------
module surng_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [surng_pkg::SEED_W-1:0] cfg_wr_data,
	input  surng_pkg::op_t               op,
	output surng_pkg::dp_status_t        status,
	input  logic                         rsp_stall,
	output logic                         rsp_valid,
	output logic [surng_pkg::VAL_W-1:0]  value
);
	import surng_pkg::*;

	val_t               mem [LEN];
	val_t               rd_a_q, rd_b_q;
	val_t               cur_q, nxt_q, value_q;
	logic [SEED_W-1:0]  seed_q;
	idx_t               cnt_q, pos_q, lead_q, trail_q;
	logic [PASS_W-1:0]  pass_q;
	logic               rsp_valid_q;

	logic               we, re;
	idx_t               waddr, ra, rb;
	val_t               wdata, diff, start_val;
	idx_t               lead_n, trail_n, pos_n, mix_b;
	logic [IDX_W:0]     pos_sum, mix_sum;

	assign diff    = sub_mod(rd_a_q, rd_b_q);
	assign lead_n  = advance(lead_q);
	assign trail_n = advance(trail_q);

	// seeds above the constant clamp, giving a start of zero
	assign start_val = (seed_q > MSEED) ? '0 : VAL_W'(MSEED - seed_q);

	assign pos_sum = {1'b0, pos_q} + (IDX_W+1)'(SCATTER);
	assign pos_n   = (pos_sum >= (IDX_W+1)'(LEN)) ?
		idx_t'(pos_sum - (IDX_W+1)'(LEN)) : idx_t'(pos_sum);
	assign mix_sum = {1'b0, cnt_q} + (IDX_W+1)'(LAG);
	assign mix_b   = (mix_sum >= (IDX_W+1)'(LEN)) ?
		idx_t'(mix_sum - (IDX_W+1)'(LEN)) : idx_t'(mix_sum);

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = '0;
		wdata = '0;
		ra    = '0;
		rb    = '0;
		unique case (op)
			OP_SEED0: begin
				we    = 1'b1;
				waddr = idx_t'(LEN - 1);
				wdata = start_val;
			end
			OP_FILL: begin
				we    = 1'b1;
				waddr = pos_q - idx_t'(1);
				wdata = nxt_q;
			end
			OP_MIX_RD: begin
				re = 1'b1;
				ra = cnt_q - idx_t'(1);
				rb = mix_b;
			end
			OP_MIX_WR: begin
				we    = 1'b1;
				waddr = cnt_q - idx_t'(1);
				wdata = diff;
			end
			OP_DRAW_RD: begin
				re = 1'b1;
				ra = lead_n - idx_t'(1);
				rb = trail_n - idx_t'(1);
			end
			OP_DRAW_WR: begin
				we    = 1'b1;
				waddr = lead_q - idx_t'(1);
				wdata = diff;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= mem[ra];
			rd_b_q <= mem[rb];
		end
	end

	// running pair of the fill sequence, and the value register on a draw write
	always_ff @(posedge clk) begin
		if (op == OP_SEED0) begin
			cur_q <= start_val;
			nxt_q <= val_t'(1);
		end else if (op == OP_FILL) begin
			cur_q <= nxt_q;
			nxt_q <= sub_mod(cur_q, nxt_q);
		end
		if (op == OP_DRAW_WR) begin
			value_q <= diff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= SEED_W'(1);
			cnt_q       <= '0;
			pos_q       <= '0;
			pass_q      <= '0;
			lead_q      <= '0;
			trail_q     <= idx_t'(TRAIL_INIT);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			unique case (op)
				OP_SEED0: begin
					cnt_q   <= idx_t'(1);
					pos_q   <= idx_t'(SCATTER);
					lead_q  <= '0;
					trail_q <= idx_t'(TRAIL_INIT);
				end
				OP_FILL: begin
					pos_q <= pos_n;
					if (status.fill_last) begin
						cnt_q  <= idx_t'(1);
						pass_q <= '0;
					end else begin
						cnt_q <= cnt_q + idx_t'(1);
					end
				end
				OP_MIX_WR: begin
					if (cnt_q == idx_t'(LEN)) begin
						cnt_q  <= idx_t'(1);
						pass_q <= pass_q + PASS_W'(1);
					end else begin
						cnt_q <= cnt_q + idx_t'(1);
					end
				end
				OP_DRAW_RD: begin
					lead_q  <= lead_n;
					trail_q <= trail_n;
				end
				default: begin
				end
			endcase
			if (op == OP_DRAW_WR) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign status.fill_last = (cnt_q == idx_t'(LEN - 1));
	assign status.mix_last  = (pass_q == PASS_W'(MIX_PASSES - 1)) && (cnt_q == idx_t'(LEN));
	assign status.out_busy  = rsp_valid_q && rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;

endmodule

/* rtl/surng_ctrl.sv */
// ----------------------------------------------------------------------------
// surng_ctrl
// sequencer for seeding, mixing and drawing
// ----------------------------------------------------------------------------
module surng_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  reseed,
	input  surng_pkg::dp_status_t status,
	output surng_pkg::op_t        op
);
	import surng_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SEED0   = 3'd1;
	localparam logic [2:0] S_FILL    = 3'd2;
	localparam logic [2:0] S_MIX_RD  = 3'd3;
	localparam logic [2:0] S_MIX_WR  = 3'd4;
	localparam logic [2:0] S_DRAW_RD = 3'd5;
	localparam logic [2:0] S_DRAW_WR = 3'd6;

	logic [2:0] state_q, state_n;
	logic       seeded_q;

	always_comb begin
		state_n = state_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_n = (reseed || !seeded_q) ? S_SEED0 : S_DRAW_RD;
				end
			end
			S_SEED0: begin
				op      = OP_SEED0;
				state_n = S_FILL;
			end
			S_FILL: begin
				op = OP_FILL;
				if (status.fill_last) begin
					state_n = S_MIX_RD;
				end
			end
			S_MIX_RD: begin
				op      = OP_MIX_RD;
				state_n = S_MIX_WR;
			end
			S_MIX_WR: begin
				op      = OP_MIX_WR;
				state_n = status.mix_last ? S_DRAW_RD : S_MIX_RD;
			end
			S_DRAW_RD: begin
				op      = OP_DRAW_RD;
				state_n = S_DRAW_WR;
			end
			S_DRAW_WR: begin
				// hold the difference until the output register frees up
				if (!status.out_busy) begin
					op      = OP_DRAW_WR;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			seeded_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_SEED0) begin
				seeded_q <= 1'b1;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

/* rtl/subtractive_uniform_rng.sv */
// ----------------------------------------------------------------------------
// subtractive_uniform_rng
// lagged subtractive uniform generator, modulus 1e9, 55-entry lag table
//
// request channel: req_valid / req_stall with reseed; a beat moves when
// req_valid is high and req_stall low. each request gives one beat on the
// response channel (rsp_valid / rsp_stall) carrying value in 0..999999999;
// value / 1e9 is the uniform fraction.
// cfg_wr_en / cfg_wr_data load the seed register (reset value 1); write it
// only while the block is idle.
// a plain draw runs in three steps per request: accept, table read and
// subtract with write-back, paced by the single lag table memory with its
// registered read port. the write-back registers the value once the output is free.
// the first request after reset, or one with reseed set, first rebuilds the
// table: a seed write, 54 fill writes and 4 x 55 mixing steps of read then write.
// reset zeroes the lead pointer, presets the trail pointer and marks the table unseeded.
// a stalled response holds; the block takes the next request meanwhile and
// waits with its new value until the response register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module subtractive_uniform_rng (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [surng_pkg::SEED_W-1:0] cfg_wr_data,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         reseed,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [surng_pkg::VAL_W-1:0]  value
);
	import surng_pkg::*;

	op_t        op;
	dp_status_t status;
	logic       req_take;

	assign req_take = req_valid && !req_stall;

	surng_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.reseed    (reseed),
		.status    (status),
		.op        (op)
	);

	surng_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.op          (op),
		.status      (status),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.value       (value)
	);

	// no request is taken while the datapath is busy
	`ASSERT_CLK(a_busy_stalls, (op != OP_NONE) |-> req_stall, "request taken while busy")
	// a new result never overwrites one still waiting
	`ASSERT_CLK(a_no_overwrite, (op == OP_DRAW_WR) |-> !(rsp_valid && rsp_stall), "overwritten")
	// an accepted request starts either seeding or a draw
	`ASSERT_CLK(a_accept_start, req_take |=> (op == OP_SEED0 || op == OP_DRAW_RD), "bad start")
	// results stay below the modulus
	`ASSERT_CLK(a_value_range, rsp_valid |-> (value < MODULUS), "value out of range")
	// nothing is offered during reset
	`ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !rsp_valid, "response during reset")

endmodule

/* tb/sv/subtractive_uniform_rng_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subtractive_uniform_rng_tb
// self-checking bench for the lagged subtractive generator: every accepted
// request is run through an in-bench copy of the 55-entry table and each
// response beat is compared in order against the predicted draw. the run
// covers seed register extremes, reseeds mid-stream and several mixes of
// sender gaps and response stalls, including a long response hold-off
// ----------------------------------------------------------------------------

import surng_pkg::*;

class draw_tracker;

	int unsigned residues [1:LEN];
	int          lead;
	int          trail;
	bit          seeded;
	int unsigned seed_mag;
	val_t        expected_values [$];
	int          mismatches;
	int          draws;
	int          rebuilds;

	function new();
		seed_mag = 1;
		lead = 0;
		trail = TRAIL_INIT;
		seeded = 1'b0;
		mismatches = 0;
		draws = 0;
		rebuilds = 0;
	endfunction

	function void set_seed(input logic [SEED_W-1:0] s);
		seed_mag = s;
	endfunction

	function int unsigned diff_mod(input int unsigned a, input int unsigned b);
		return (a >= b) ? a - b : a + MODULUS - b;
	endfunction

	function int next_pos(input int p);
		return (p >= 1 && p < LEN) ? p + 1 : 1;
	endfunction

	function void rebuild_table();
		int unsigned start;
		int unsigned cur;
		int unsigned nxt;
		int          pos;
		int          i;
		int          round;
		start = (seed_mag > MSEED) ? MSEED : seed_mag;
		cur = MSEED - start;
		nxt = 1;
		residues[LEN] = cur;
		// scattered fill, 21 is coprime to 55 so no position repeats
		for (i = 1; i < LEN; i++) begin
			pos = (SCATTER * i) % LEN;
			residues[pos] = nxt;
			nxt = diff_mod(cur, nxt);
			cur = residues[pos];
		end
		for (round = 0; round < MIX_PASSES; round++) begin
			for (i = 1; i <= LEN; i++) begin
				residues[i] = diff_mod(residues[i], residues[1 + (i + LAG) % LEN]);
			end
		end
		lead = 0;
		trail = TRAIL_INIT;
		seeded = 1'b1;
		rebuilds++;
	endfunction

	function void note_request(input bit reseed_bit);
		int unsigned d;
		if (reseed_bit || !seeded) begin
			rebuild_table();
		end
		lead = next_pos(lead);
		trail = next_pos(trail);
		d = diff_mod(residues[lead], residues[trail]);
		residues[lead] = d;
		expected_values.push_back(val_t'(d));
		draws++;
	endfunction

	function void check_value(input val_t got);
		val_t want;
		if (expected_values.size() == 0) begin
			$display("%0t: unexpected value beat, expected none, got %0d", $time, got);
			mismatches++;
		end else begin
			want = expected_values.pop_front();
			if (got !== want) begin
				$display("%0t: value mismatch, expected %0d, got %0d", $time, want, got);
				mismatches++;
			end
		end
	endfunction

endclass

module subtractive_uniform_rng_tb;

	localparam int RESET_CYCLES = 7;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 200;
	localparam int SETTLE       = 6;
	localparam int TAIL_CYCLES  = 20;
	localparam int RESEED_PCT   = 4;
	localparam bit DRAW         = 1'b0;
	localparam bit RESEED       = 1'b1;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [SEED_W-1:0] cfg_wr_data;
	logic              req_valid;
	logic              req_stall;
	logic              reseed;
	logic              rsp_valid;
	logic              rsp_stall;
	val_t              value;

	int sender_pct;
	int receiver_pct;
	int hold_asked;
	int hold_done;
	int hold_left;
	int quiet_cycles;
	int seeds_written;

	draw_tracker tracker = new();

	subtractive_uniform_rng dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.reseed      (reseed),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.value       (value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response side stalls, with a long hold-off whenever one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (hold_done != hold_asked) begin
			hold_done <= hold_done + 1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < receiver_pct);
		end
	end

	// beat monitor and watchdog
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			tracker.check_value(value);
		end
		if (arst_n && req_valid && !req_stall) begin
			tracker.note_request(reseed);
		end
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d values outstanding", $time,
				QUIET_LIMIT, tracker.expected_values.size());
			$display("** subtractive_uniform_rng: FAILED **");
			$finish;
		end
	end

	task automatic set_mode(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				sender_pct <= 0;
				receiver_pct <= 0;
			end
			IDLE_SENDER: begin
				sender_pct <= 56;
				receiver_pct <= 0;
			end
			IDLE_RECEIVER: begin
				sender_pct <= 0;
				receiver_pct <= 56;
			end
			default: begin
				sender_pct <= 16;
				receiver_pct <= 16;
			end
		endcase
	endtask

	// only called with the block idle
	task automatic write_seed(input logic [SEED_W-1:0] s);
		cfg_wr_data <= s;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_seed(s);
		seeds_written++;
	endtask

	// returns at the edge where the beat is taken, valid left high
	task automatic send_request(input bit rs);
		while ($urandom_range(99) < sender_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		reseed <= rs;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic send_random(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			send_request(($urandom_range(99) < RESEED_PCT) ? RESEED : DRAW);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (tracker.expected_values.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input idle_mode_t mode, input logic [SEED_W-1:0] s,
		input int n);
		set_mode(mode);
		write_seed(s);
		send_request(RESEED);
		send_random(n - 1);
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		req_valid <= 1'b0;
		reseed <= 1'b0;
		sender_pct <= 0;
		receiver_pct <= 0;
		hold_asked <= 0;
		seeds_written = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first draw seeds from the reset seed, then a reseed while seeded
		send_request(DRAW);
		send_request(DRAW);
		send_request(DRAW);
		send_request(RESEED);
		send_request(DRAW);
		drain();
		// zero seed, the new value only counts once reseeded
		write_seed('0);
		send_request(DRAW);
		send_request(RESEED);
		send_request(DRAW);
		drain();
		write_seed(MSEED);
		send_request(RESEED);
		send_request(DRAW);
		drain();
		// above range clamps to the top
		write_seed('1);
		send_request(RESEED);
		send_request(DRAW);
		drain();
		write_seed(MSEED + 1'b1);
		send_request(RESEED);
		send_request(DRAW);
		drain();

		run_phase(IDLE_NONE, SEED_W'($urandom_range(MSEED)), 80);
		run_phase(IDLE_SENDER, SEED_W'($urandom), 80);
		run_phase(IDLE_RECEIVER, SEED_W'($urandom_range(MSEED)), 80);
		run_phase(IDLE_BOTH, SEED_W'($urandom), 80);

		// long response hold-off while requests keep coming, then a full pause
		set_mode(IDLE_NONE);
		write_seed(SEED_W'($urandom_range(MSEED)));
		send_request(RESEED);
		send_random(19);
		hold_asked <= hold_asked + 1;
		send_random(40);
		drain();
		send_random(20);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d draws checked, %0d table rebuilds, %0d seed writes", tracker.draws,
			tracker.rebuilds, seeds_written);
		$display("idling: none, sender gaps, response stalls, both, and a long hold-off");
		if (tracker.mismatches == 0 && tracker.expected_values.size() == 0) begin
			$display("** subtractive_uniform_rng: PASSED **");
		end else begin
			$display("** subtractive_uniform_rng: FAILED **");
		end
		$finish;
	end

endmodule

/* subtractive_uniform_rng.f */
+incdir+rtl
rtl/surng_pkg.sv
rtl/surng_dp.sv
rtl/surng_ctrl.sv
rtl/subtractive_uniform_rng.sv
tb/sv/subtractive_uniform_rng_tb.sv
